// ===== design/plig_pkg.sv =====
package plig_pkg;

    localparam int DEPTH_DEF = 128;

    // operation codes
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_GET    = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;
    localparam logic [1:0] FN_NOP    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_data;
        logic [7:0]         count;
        logic               is_empty;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_WR,
        S_GET_RD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic shift_rd;
        logic shift_wr;
        logic ins_wr;
        logic get_rd;
        logic clear;
        logic load_res;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       op_ok;
        logic       shift_more;
        logic       shift_again;
        logic       res_free;
    } stat_t;

endpackage

// ===== design/plig_ctrl.sv =====
module plig_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  plig_pkg::stat_t stat,
    output plig_pkg::cmd_t  cmd
);

    plig_pkg::state_t state_reg;
    plig_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plig_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plig_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = plig_pkg::S_DECODE;
                end
            end
            plig_pkg::S_DECODE:
            begin
                if (!stat.op_ok)
                begin
                    state_next = plig_pkg::S_DONE;
                end
                else if (stat.func == plig_pkg::FN_INSERT)
                begin
                    state_next = stat.shift_more ? plig_pkg::S_SHIFT_RD : plig_pkg::S_INS_WR;
                end
                else if (stat.func == plig_pkg::FN_GET)
                begin
                    state_next = plig_pkg::S_GET_RD;
                end
                else
                begin
                    state_next = plig_pkg::S_DONE;
                end
            end
            plig_pkg::S_SHIFT_RD:
            begin
                state_next = plig_pkg::S_SHIFT_WR;
            end
            plig_pkg::S_SHIFT_WR:
            begin
                state_next = stat.shift_again ? plig_pkg::S_SHIFT_RD : plig_pkg::S_INS_WR;
            end
            plig_pkg::S_INS_WR:
            begin
                state_next = plig_pkg::S_DONE;
            end
            plig_pkg::S_GET_RD:
            begin
                state_next = plig_pkg::S_DONE;
            end
            plig_pkg::S_DONE:
            begin
                if (stat.res_free)
                begin
                    state_next = plig_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = plig_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            plig_pkg::S_IDLE:
            begin
                req_stall  = 1'b0;
                cmd.accept = req_valid;
            end
            plig_pkg::S_DECODE:
            begin
                cmd.clear = stat.op_ok && (stat.func == plig_pkg::FN_CLEAR);
            end
            plig_pkg::S_SHIFT_RD:
            begin
                cmd.shift_rd = 1'b1;
            end
            plig_pkg::S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
            end
            plig_pkg::S_INS_WR:
            begin
                cmd.ins_wr = 1'b1;
            end
            plig_pkg::S_GET_RD:
            begin
                cmd.get_rd = 1'b1;
            end
            plig_pkg::S_DONE:
            begin
                cmd.load_res = stat.res_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/plig_dpath.sv =====
module plig_dpath #(
    parameter int DEPTH = plig_pkg::DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  plig_pkg::req_t  req,
    input  plig_pkg::cmd_t  cmd,
    output plig_pkg::stat_t stat,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output plig_pkg::rsp_t  rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 8) ? CW : 8;
    localparam int EW = PW + 1;

    logic [1:0]         func_reg;
    logic [7:0]         pos_reg;
    logic signed [31:0] value_reg;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic [CW-1:0]      fill_reg;
    logic [CW-1:0]      fill_next;
    logic [CW-1:0]      k_reg;
    logic [CW-1:0]      k_next;
    logic signed [31:0] rd_data_reg;
    logic signed [31:0] mem [DEPTH];
    plig_pkg::rsp_t     rsp_reg;
    plig_pkg::rsp_t     rsp_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;

    logic [EW-1:0]      pos_ext;
    logic [EW-1:0]      fill_ext;
    logic               range_ins;
    logic               range_get;
    logic               full;
    logic [PW-1:0]      posm1;
    logic [PW-1:0]      k_ext;
    logic [PW-1:0]      fill_pw;
    logic [CW-1:0]      km1;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    // status is settled against the fill at accept time
    always_comb
    begin
        pos_ext   = EW'(req.position);
        fill_ext  = EW'(fill_reg);
        range_ins = (req.position == 8'd0) || (pos_ext > fill_ext + EW'(1));
        range_get = (req.position == 8'd0) || (pos_ext > fill_ext);
        full      = (fill_reg == CW'(DEPTH));
        status_next = plig_pkg::ST_OK;
        if (req.func == plig_pkg::FN_INSERT)
        begin
            if (range_ins)
            begin
                status_next = plig_pkg::ST_RANGE;
            end
            else if (full)
            begin
                status_next = plig_pkg::ST_FULL;
            end
        end
        else if (req.func == plig_pkg::FN_GET)
        begin
            if (range_get)
            begin
                status_next = plig_pkg::ST_RANGE;
            end
        end
    end

    always_comb
    begin
        posm1   = PW'(pos_reg) - PW'(1);
        k_ext   = PW'(k_reg);
        km1     = k_reg - CW'(1);
        fill_pw = PW'(fill_reg);

        stat.func        = func_reg;
        stat.op_ok       = (status_reg == plig_pkg::ST_OK);
        stat.shift_more  = (k_ext > posm1);
        stat.shift_again = (k_ext > PW'(pos_reg));
        stat.res_free    = !rsp_valid_reg || !rsp_stall;

        rd_en   = cmd.shift_rd || cmd.get_rd;
        rd_addr = cmd.get_rd ? posm1[AW-1:0] : km1[AW-1:0];
        wr_en   = cmd.shift_wr || cmd.ins_wr;
        wr_addr = cmd.ins_wr ? posm1[AW-1:0] : k_reg[AW-1:0];
        wr_data = cmd.ins_wr ? value_reg : rd_data_reg;

        fill_next = fill_reg;
        if (cmd.clear)
        begin
            fill_next = '0;
        end
        else if (cmd.ins_wr)
        begin
            fill_next = fill_reg + CW'(1);
        end

        k_next = k_reg;
        if (cmd.accept)
        begin
            k_next = fill_reg;
        end
        else if (cmd.shift_wr)
        begin
            k_next = km1;
        end

        rsp_next.status    = status_reg;
        rsp_next.read_data = ((func_reg == plig_pkg::FN_GET) && (status_reg == plig_pkg::ST_OK))
                             ? rd_data_reg : 32'sd0;
        rsp_next.count     = fill_pw[7:0];
        rsp_next.is_empty  = (fill_reg == '0);

        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_res)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg   <= req.func;
            pos_reg    <= req.position;
            value_reg  <= req.value;
            status_reg <= status_next;
        end
        k_reg <= k_next;
        if (cmd.load_res)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== design/positional_list_insert_get.sv =====
// Channel   Dir  Handshake              Payload
// req       in   req_valid / req_stall  plig_pkg::req_t (func, position, value)
// rsp       out  rsp_valid / rsp_stall  plig_pkg::rsp_t (status, read_data, count, is_empty)
//
// One item at a time. Clear, unused codes and failed operations pass decode and done;
// get adds a memory read; insert moves the count - position + 1 entries from position
// on up by one, each by a read and a write on the entry memory, then writes the value.
// Reset clears the entry count, the result valid flag and the controller state; the entry memory is not swept.
// The result register lets a new item in while the previous result is stalled;
// the block then holds in its last state until that register frees up.
module positional_list_insert_get #(
    parameter int DEPTH = plig_pkg::DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  plig_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output plig_pkg::rsp_t rsp
);

    plig_pkg::cmd_t  cmd;
    plig_pkg::stat_t stat;

    plig_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    plig_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== design/plig_chk.sv =====
module plig_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input plig_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input plig_pkg::rsp_t rsp
);

    // an accepted item keeps the input closed for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("input open right after accepting an item");

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req))
        else $error("stalled input item dropped or changed");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.is_empty == (rsp.count == 8'd0)))
        else $error("empty flag disagrees with count");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != plig_pkg::ST_OK) |-> (rsp.read_data == 32'sd0))
        else $error("read data nonzero on failed operation");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result dropped or changed");

endmodule

bind positional_list_insert_get plig_chk u_plig_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
